// ===== sv/oli_pkg.sv =====
// oli_pkg: shared constants, operation and status codes, and the command
// struct for the ordered list block
// no dependencies
`default_nettype none

package oli_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERASE      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/oli_ctrl.sv =====
// oli_ctrl: handshake controller for the ordered list
// depends on oli_pkg
`default_nettype none

module oli_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output oli_pkg::cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // no word is taken while reset is held
    assign s_tready = aresetn &&
                      ((state_reg == S_IDLE) || ((state_reg == S_OUT) && m_tready));
    assign m_tvalid = (state_reg == S_OUT);
    assign accept   = s_tvalid && s_tready;

    assign cmd.load = accept;
    assign cmd.exec = (state_reg == S_EXEC);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) state_next = accept ? S_EXEC : S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/oli_dp.sv =====
// oli_dp: operation register, entry count, row of shifting entry cells and
// result register
// depends on oli_pkg
`default_nettype none

module oli_dp #(
    parameter int CAPACITY   = oli_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = oli_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire oli_pkg::cmd_t                  cmd,
    input  wire logic [oli_pkg::KIND_W-1:0]     in_kind,
    input  wire logic [oli_pkg::POS_W-1:0]      in_position,
    input  wire logic [oli_pkg::VAL_W-1:0]      in_value,
    output logic      [oli_pkg::STATUS_W-1:0]   out_status,
    output logic      [oli_pkg::CNT_W-1:0]      out_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > oli_pkg::POS_W) ? CW : oli_pkg::POS_W;

    logic [oli_pkg::KIND_W-1:0]   kind_reg;
    logic [oli_pkg::POS_W-1:0]    pos_reg;
    logic [DATA_WIDTH-1:0]        val_reg;
    logic [63:0]                  val_wide;

    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [oli_pkg::STATUS_W-1:0] status_reg;
    logic [oli_pkg::STATUS_W-1:0] status_next;
    logic [oli_pkg::CNT_W-1:0]    rcount_reg;

    logic [DATA_WIDTH-1:0] entries_reg  [CAPACITY];
    logic [DATA_WIDTH-1:0] entries_next [CAPACITY];

    logic          ins;
    logic          era;
    logic [PW-1:0] at;
    logic [PW-1:0] count_ext;
    logic [PW-1:0] pos_ext;
    logic          full;
    logic          empty;

    // value kept in the low data width bits, zero-extended when wider
    assign val_wide  = {32'd0, in_value};
    assign count_ext = PW'(count_reg);
    assign pos_ext   = PW'(pos_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;
            pos_reg  <= in_position;
            val_reg  <= val_wide[DATA_WIDTH-1:0];
        end
    end

    always_comb begin
        ins         = 1'b0;
        era         = 1'b0;
        at          = '0;
        status_next = oli_pkg::ST_OK;
        count_next  = count_reg;
        unique case (kind_reg)
            oli_pkg::KIND_PUSH_BACK: begin
                if (full) status_next = oli_pkg::ST_FULL;
                else begin
                    ins = 1'b1;
                    at  = count_ext;
                end
            end
            oli_pkg::KIND_PUSH_FRONT: begin
                if (full) status_next = oli_pkg::ST_FULL;
                else ins = 1'b1;
            end
            oli_pkg::KIND_POP_BACK: begin
                if (empty) status_next = oli_pkg::ST_EMPTY;
                else count_next = count_reg - CW'(1);
            end
            oli_pkg::KIND_POP_FRONT: begin
                if (empty) status_next = oli_pkg::ST_EMPTY;
                else era = 1'b1;
            end
            oli_pkg::KIND_INSERT: begin
                if (pos_ext > count_ext) status_next = oli_pkg::ST_BADPOS;
                else if (full) status_next = oli_pkg::ST_FULL;
                else begin
                    ins = 1'b1;
                    at  = pos_ext;
                end
            end
            oli_pkg::KIND_ERASE: begin
                if (pos_ext >= count_ext) status_next = oli_pkg::ST_BADPOS;
                else begin
                    era = 1'b1;
                    at  = pos_ext;
                end
            end
            oli_pkg::KIND_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
        if (ins) count_next = count_reg + CW'(1);
        if (era) count_next = count_reg - CW'(1);
    end

    // each cell takes its lower neighbour on insert, its upper on erase
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [PW-1:0] IDX  = PW'(i);
        localparam logic [PW-1:0] IDX1 = PW'(i + 1);
        logic [DATA_WIDTH-1:0] lower;
        logic [DATA_WIDTH-1:0] upper;

        if (i == 0) begin : g_lo_edge
            assign lower = val_reg;
        end else begin : g_lo
            assign lower = entries_reg[i-1];
        end
        if (i == CAPACITY - 1) begin : g_hi_edge
            assign upper = entries_reg[i];
        end else begin : g_hi
            assign upper = entries_reg[i+1];
        end

        always_comb begin
            entries_next[i] = entries_reg[i];
            if (ins) begin
                if (IDX == at) entries_next[i] = val_reg;
                else if ((IDX > at) && (IDX <= count_ext)) entries_next[i] = lower;
            end else if (era) begin
                if ((IDX >= at) && (IDX1 < count_ext)) entries_next[i] = upper;
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.exec) begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            rcount_reg <= count_next[oli_pkg::CNT_W-1:0];
        end
    end

    assign out_status = status_reg;
    assign out_count  = rcount_reg;

endmodule

`default_nettype wire

// ===== sv/ordered_list_insert_erase.sv =====
// ordered list with insert and erase: an accepted input word is registered in
// the operation register, then the cell row and the result register update in
// the exec state, and the result word is held until it is taken
// the next word is taken in the cycle its predecessor's result is taken
// aresetn (synchronous, active low) empties the list; entry contents stay
`default_nettype none

module ordered_list_insert_erase #(
    parameter int CAPACITY   = oli_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = oli_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [oli_pkg::S_TDATA_W-1:0]   s_tdata,  // position[6:0], value[38:7], pad
    input  wire logic [oli_pkg::KIND_W-1:0]      s_tuser,  // kind[2:0]
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [oli_pkg::M_TDATA_W-1:0]   m_tdata   // status[1:0], count[8:2], pad
);

    oli_pkg::cmd_t                  cmd;
    logic [oli_pkg::STATUS_W-1:0]   status;
    logic [oli_pkg::CNT_W-1:0]      count;

    // controller: accepts a word, runs the update in its exec state, then holds the result
    oli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath: count, row of entry cells that shift together, result register
    oli_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_kind     (s_tuser),
        .in_position (s_tdata[oli_pkg::POS_W-1:0]),
        .in_value    (s_tdata[oli_pkg::POS_W+oli_pkg::VAL_W-1:oli_pkg::POS_W]),
        .out_status  (status),
        .out_count   (count)
    );

    // result word: status in the low bits, count above, zero padding on top
    assign m_tdata = {
        {(oli_pkg::M_TDATA_W - oli_pkg::STATUS_W - oli_pkg::CNT_W){1'b0}},
        count,
        status
    };

endmodule

`default_nettype wire
